FILE: rtl/sacr_pkg.sv
// ============================================================================
// sacr_pkg: shared constants and types for the signed-area coverage rasterizer
// Tile geometry, fixed-point scaling, opcodes, register indexes and the
// request/response bundles of the shared divider.
// ============================================================================
package sacr_pkg;

  // Tile geometry and cell store layout.
  localparam int TILE_COLUMNS    = 64;
  localparam int TILE_ROWS       = 64;
  localparam int COORD_FRAC_BITS = 8;
  localparam int CELL_STRIDE     = TILE_COLUMNS + 2;
  localparam int CELL_COUNT      = TILE_ROWS * CELL_STRIDE;
  localparam int CELL_ADDR_W     = $clog2(CELL_COUNT);
  localparam int CELL_W          = 16;

  // Edge x positions are carried in Q16 pixels.
  localparam int XQ     = 16;
  localparam int XSC    = XQ - COORD_FRAC_BITS;
  localparam int XSHIFT = XSC + 1;

  // Coverage scale: 4096 is a fully covered pixel.
  localparam int FULL_COVER = 4096;

  // Shared divider sizes.
  localparam int DIV_NUM_W = 58;
  localparam int DIV_DEN_W = 37;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // Register reset values.
  localparam logic [6:0] TILE_WIDTH_RST  = 7'd64;
  localparam logic [6:0] TILE_HEIGHT_RST = 7'd64;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_EDGE  = 2'd1,
    OP_FILL  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_TILE_WIDTH  = 2'd0,
    REG_TILE_HEIGHT = 2'd1,
    REG_ANTIALIAS   = 2'd2,
    REG_EVEN_ODD    = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
    logic [DIV_DEN_W-1:0] remainder;
  } div_rsp_t;

  // Base address of one row of cells.
  function automatic logic [CELL_ADDR_W-1:0] row_base(input logic [6:0] row);
    row_base = CELL_ADDR_W'(row) * CELL_ADDR_W'(CELL_STRIDE);
  endfunction

endpackage

FILE: rtl/sacr_div.sv
// ============================================================================
// sacr_div: shared restoring divider
// Unsigned division, one quotient bit per cycle. A done pulse marks the cycle
// in which quotient and remainder are final; they hold until the next start.
// ============================================================================
module sacr_div (
  input  logic               clk,
  input  logic               rst,
  input  sacr_pkg::div_req_t req,
  output sacr_pkg::div_rsp_t rsp
);
  import sacr_pkg::*;

  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 run;
  logic                 done;
  logic [DIV_DEN_W:0]   trial;
  logic                 ge;
  logic [DIV_DEN_W-1:0] rem_next;

  // One trial subtraction per cycle.
  always_comb begin
    trial    = {rem, quo[DIV_NUM_W-1]};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? DIV_DEN_W'(trial - {1'b0, dvs}) : trial[DIV_DEN_W-1:0];
  end

  // Control resets; the datapath registers do not need to.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
      end else if (run && cnt == DIV_CNT_W'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
      cnt <= DIV_CNT_W'(DIV_NUM_W);
    end else if (run) begin
      quo <= {quo[DIV_NUM_W-2:0], ge};
      rem <= rem_next;
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

FILE: rtl/signed_area_coverage_rasterizer_top.sv
// ============================================================================
// signed_area_coverage_rasterizer_top: analytic-coverage tile rasterizer
// Accumulates signed trapezoid areas of edges into a tile of 16-bit cells and
// resolves one row at a time into per-pixel alpha with a non-zero or even-odd
// fold.
// ============================================================================
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+---------------------------------------------
//  command  | start, busy        | opcode, edge_*_start/end, fill_row_index
//  config   | wr_en              | wr_index, wr_data
//  result   | valid (one cycle)  | pixel_column, pixel_row, alpha, last_in_row
//
//  An item is taken when start is high and busy is low.
//  Clear: one cell per cycle over all 4224 cells. The same sweep runs after
//  reset, so busy stays high after rst falls until the sweep completes.
//  Edge: per row crossed, two divisions for the edge x positions
//  (one after the first row) and one division per touched cell, all on
//  the shared bit-serial divider.
//  Fill: per pixel a cell read, then an accumulate, one result each.
//  Results are strobed for one cycle and cannot be stalled.
//
module signed_area_coverage_rasterizer_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic signed [23:0] edge_x_start,
  input  logic signed [23:0] edge_y_start,
  input  logic signed [23:0] edge_x_end,
  input  logic signed [23:0] edge_y_end,
  input  logic [5:0]         fill_row_index,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [6:0]         wr_data,
  output logic               valid,
  output logic [5:0]         pixel_column,
  output logic [5:0]         pixel_row,
  output logic [7:0]         alpha,
  output logic               last_in_row
);
  import sacr_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_E_CHK, S_R_BEGIN, S_X_MUL, S_X_DIV, S_X_WAIT,
    S_R_GEOM, S_SQ_HEAD, S_SQ_TAIL, S_C_NUM, S_C_MUL, S_C_DIV, S_C_WAIT,
    S_R_NEXT, S_F_RD, S_F_ACC
  } state_t;

  state_t state;

  // Configuration registers.
  logic [6:0] tile_width;
  logic [6:0] tile_height;
  logic       antialias_on;
  logic       even_odd_rule;

  // Edge and row walk registers.
  logic [CELL_ADDR_W-1:0] clr_addr;
  logic signed [23:0] ex0, ey0, ex1, ey1;
  logic               neg;
  logic signed [24:0] dx;
  logic [24:0]        dye;
  logic [14:0]        ytop, ybot, ryt, ryb;
  logic [6:0]         ys, ye, yrow;
  logic [8:0]         dy;
  logic               need_xa;
  logic               xsel;
  logic               x_neg;
  logic signed [49:0] prod;
  logic [22:0]        xa, xb;

  // Per-row span geometry.
  logic [6:0]  x0i, x1i;
  logic [22:0] lspan;
  logic [15:0] f0;
  logic [16:0] g0, f1;
  logic [18:0] mpos;
  logic        single;
  logic [32:0] head, tail;
  logic [6:0]  ccol;
  logic signed [41:0] num;
  logic        csign;

  // Fill registers.
  logic [5:0]         frow;
  logic [6:0]         fcol;
  logic signed [22:0] acc;

  // Cell store.
  logic [CELL_W-1:0]      mem [CELL_COUNT];
  logic [CELL_W-1:0]      mem_q;
  logic                   mem_we, mem_re;
  logic [CELL_ADDR_W-1:0] mem_waddr, mem_raddr, cell_addr, fill_addr;
  logic [CELL_W-1:0]      mem_wdata;

  // Shared multiplier and divider.
  logic signed [41:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [67:0] mul_p;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Combinational helpers.
  logic [6:0]         w_eff, h_eff;
  logic [14:0]        hq;
  logic [22:0]        wq;
  logic signed [23:0] hq_s;
  logic               edge_skip;
  logic [14:0]        ytop_c, ybot_c, ryt_c, ryb_c, rnext;
  logic [14:0]        ybot_rnd;
  logic [14:0]        yq;
  logic signed [25:0] ydiff;
  logic signed [58:0] nx;
  logic [57:0]        nx_mag;
  logic [35:0]        qm;
  logic signed [35:0] qs, xv;
  logic [22:0]        xclamp;
  logic [22:0]        gx0, gx1;
  logic [23:0]        x1r;
  logic [6:0]         gx0i, gx1i;
  logic [22:0]        x1off;
  logic signed [41:0] d_full, a1n, kmid, head42, tail42, mid, num_c;
  logic [49:0]        pmag;
  logic [35:0]        den;
  logic [15:0]        delta;
  logic signed [22:0] acc_n;
  logic [22:0]        cabs;
  logic [12:0]        ce, cf;
  logic [20:0]        a21;
  logic [8:0]         a9;
  logic [7:0]         alpha_c;
  logic               fill_last;

  sacr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Effective tile size: zero reads as one, large values clamp to the tile.
  always_comb begin
    if (tile_width == 7'd0) w_eff = 7'd1;
    else if (tile_width > 7'(TILE_COLUMNS)) w_eff = 7'(TILE_COLUMNS);
    else w_eff = tile_width;
    if (tile_height == 7'd0) h_eff = 7'd1;
    else if (tile_height > 7'(TILE_ROWS)) h_eff = 7'(TILE_ROWS);
    else h_eff = tile_height;
    hq   = 15'(h_eff) << COORD_FRAC_BITS;
    wq   = 23'(w_eff) << XQ;
    hq_s = $signed(24'(hq));
  end

  assign busy = (state != S_IDLE);

  // Edge range check and clipping to the tile rows.
  always_comb begin
    edge_skip = (ey0 == ey1) || (ey1 <= 24'sd0) || (ey0 >= hq_s);
    ytop_c    = ey0[23] ? 15'd0 : ey0[14:0];
    ybot_c    = (ey1 > hq_s) ? hq : ey1[14:0];
    ybot_rnd  = ybot_c + 15'((1 << COORD_FRAC_BITS) - 1);
  end

  // Row bounds for the current row.
  always_comb begin
    rnext = 15'(yrow + 7'd1) << COORD_FRAC_BITS;
    ryt_c = (yrow == ys) ? ytop : (15'(yrow) << COORD_FRAC_BITS);
    ryb_c = (rnext > ybot) ? ybot : rnext;
  end

  // Edge x at a row boundary: floor division of the scaled offset.
  always_comb begin
    yq     = xsel ? ryb : ryt;
    ydiff  = $signed(26'(yq)) - 26'(ey0);
    nx     = (59'(prod) <<< XSHIFT) + $signed(59'(dye));
    nx_mag = nx[58] ? 58'(-nx) : 58'(nx);
    qm     = div_rsp.quotient[35:0] + 36'(x_neg && (div_rsp.remainder != '0));
    qs     = x_neg ? -$signed(qm) : $signed(qm);
    xv     = (36'(ex0) <<< XSC) + qs;
    if (xv < 36'sd0) xclamp = 23'd0;
    else if (xv > $signed(36'(wq))) xclamp = wq;
    else xclamp = xv[22:0];
  end

  // Span geometry from the two clamped x positions.
  always_comb begin
    gx0   = (xa < xb) ? xa : xb;
    gx1   = (xa < xb) ? xb : xa;
    gx0i  = gx0[22:16];
    x1r   = 24'(gx1) + 24'((1 << XQ) - 1);
    gx1i  = 7'(x1r >> XQ);
    x1off = gx1 - (23'(gx0i) << XQ);
  end

  // Area numerator of the current cell.
  always_comb begin
    d_full = 42'(lspan) << 17;
    a1n    = 42'(17'd98304 - 17'(f0)) << 17;
    kmid   = 42'(x1i - x0i - 7'd3) << 33;
    head42 = 42'(head);
    tail42 = 42'(tail);
    mid    = 42'(1) << 33;
    if (single) begin
      num_c = (ccol == x0i) ? (42'(1) << 17) - 42'(mpos) : 42'(mpos);
    end else if (ccol == x0i) begin
      num_c = head42;
    end else if (ccol == x1i) begin
      num_c = tail42;
    end else if (x1i == x0i + 7'd2) begin
      num_c = d_full - head42 - tail42;
    end else if (ccol == x0i + 7'd1) begin
      num_c = a1n - head42;
    end else if (ccol == x1i - 7'd1) begin
      num_c = d_full - a1n - kmid - tail42;
    end else begin
      num_c = mid;
    end
  end

  // Rounding division setup for a cell delta.
  always_comb begin
    pmag  = prod[49] ? 50'(-prod) : 50'(prod);
    den   = single ? 36'(8192) : (36'(lspan) << 13);
    delta = div_rsp.quotient[15:0];
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = 42'(ydiff);
    mul_b = 26'(dx);
    case (state)
      S_SQ_HEAD: begin
        mul_a = 42'(g0);
        mul_b = 26'(g0);
      end
      S_SQ_TAIL: begin
        mul_a = 42'(f1);
        mul_b = 26'(f1);
      end
      S_C_MUL: begin
        mul_a = num;
        mul_b = 26'(dy);
      end
      default: begin
        mul_a = 42'(ydiff);
        mul_b = 26'(dx);
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Divider requests.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = nx_mag;
    div_req.divisor  = DIV_DEN_W'(dye) << 1;
    case (state)
      S_X_DIV: div_req.start = 1'b1;
      S_C_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = (58'(pmag) << 1) + 58'(den);
        div_req.divisor  = DIV_DEN_W'(den) << 1;
      end
      default: div_req.start = 1'b0;
    endcase
  end

  // Fill: prefix sum, winding fold and alpha.
  always_comb begin
    acc_n = acc + 23'($signed(mem_q));
    cabs  = acc_n[22] ? 23'(-acc_n) : 23'(acc_n);
    if (even_odd_rule) begin
      ce = cabs[12:0];
      cf = (ce > 13'(FULL_COVER)) ? 13'(14'(2 * FULL_COVER) - 14'(ce)) : ce;
    end else begin
      ce = cabs[12:0];
      cf = (cabs > 23'(FULL_COVER)) ? 13'(FULL_COVER) : cabs[12:0];
    end
    a21 = {cf, 8'd0} - 21'(cf);
    a9  = a21[20:12];
    if (antialias_on) alpha_c = (a9 > 9'd255) ? 8'd255 : a9[7:0];
    else alpha_c = (cf >= 13'(FULL_COVER / 2)) ? 8'd255 : 8'd0;
    fill_last = (fcol == w_eff - 7'd1);
  end

  // Cell store port selection.
  always_comb begin
    cell_addr = row_base(yrow) + CELL_ADDR_W'(ccol);
    fill_addr = row_base(7'(frow)) + CELL_ADDR_W'(fcol);
    mem_we    = 1'b0;
    mem_waddr = cell_addr;
    mem_wdata = mem_q + (csign ? 16'(-delta) : delta);
    mem_re    = 1'b0;
    mem_raddr = cell_addr;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_C_DIV: mem_re = 1'b1;
      S_C_WAIT: mem_we = div_rsp.done;
      S_F_RD: begin
        mem_re    = 1'b1;
        mem_raddr = fill_addr;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q <= mem[mem_raddr];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_width    <= TILE_WIDTH_RST;
      tile_height   <= TILE_HEIGHT_RST;
      antialias_on  <= 1'b1;
      even_odd_rule <= 1'b0;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_TILE_WIDTH:  tile_width    <= wr_data;
        REG_TILE_HEIGHT: tile_height   <= wr_data;
        REG_ANTIALIAS:   antialias_on  <= wr_data[0];
        REG_EVEN_ODD:    even_odd_rule <= wr_data[0];
        default:         tile_width    <= tile_width;
      endcase
    end
  end

  // Sequencer and registered result outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      valid    <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + CELL_ADDR_W'(1);
          if (clr_addr == CELL_ADDR_W'(CELL_COUNT - 1)) state <= S_IDLE;
        end

        S_IDLE: begin
          if (start) begin
            case (opcode_t'(opcode))
              OP_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
              OP_EDGE: begin
                // Orient downward and remember the winding sign.
                if (edge_y_start > edge_y_end) begin
                  ex0 <= edge_x_end;
                  ey0 <= edge_y_end;
                  ex1 <= edge_x_start;
                  ey1 <= edge_y_start;
                  neg <= 1'b1;
                end else begin
                  ex0 <= edge_x_start;
                  ey0 <= edge_y_start;
                  ex1 <= edge_x_end;
                  ey1 <= edge_y_end;
                  neg <= 1'b0;
                end
                state <= S_E_CHK;
              end
              OP_FILL: begin
                if (7'(fill_row_index) < h_eff) begin
                  frow  <= fill_row_index;
                  fcol  <= 7'd0;
                  acc   <= '0;
                  state <= S_F_RD;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        S_E_CHK: begin
          if (edge_skip) begin
            state <= S_IDLE;
          end else begin
            dx      <= 25'(ex1) - 25'(ex0);
            dye     <= 25'(ey1) - 25'(ey0);
            ytop    <= ytop_c;
            ybot    <= ybot_c;
            ys      <= 7'(ytop_c >> COORD_FRAC_BITS);
            ye      <= 7'(ybot_rnd >> COORD_FRAC_BITS);
            yrow    <= 7'(ytop_c >> COORD_FRAC_BITS);
            need_xa <= 1'b1;
            state   <= S_R_BEGIN;
          end
        end

        S_R_BEGIN: begin
          ryt <= ryt_c;
          ryb <= ryb_c;
          dy  <= 9'(ryb_c - ryt_c);
          if (ryb_c <= ryt_c) begin
            need_xa <= 1'b1;
            state   <= S_R_NEXT;
          end else begin
            xsel  <= !need_xa;
            state <= S_X_MUL;
          end
        end

        S_X_MUL: begin
          prod  <= mul_p[49:0];
          state <= S_X_DIV;
        end

        S_X_DIV: begin
          x_neg <= nx[58];
          state <= S_X_WAIT;
        end

        S_X_WAIT: begin
          if (div_rsp.done) begin
            if (!xsel) begin
              xa    <= xclamp;
              xsel  <= 1'b1;
              state <= S_X_MUL;
            end else begin
              xb    <= xclamp;
              state <= S_R_GEOM;
            end
          end
        end

        S_R_GEOM: begin
          x0i     <= gx0i;
          x1i     <= gx1i;
          lspan   <= gx1 - gx0;
          f0      <= gx0[15:0];
          g0      <= 17'(1 << XQ) - 17'(gx0[15:0]);
          f1      <= (gx1[15:0] == 16'd0) ? 17'(1 << XQ) : 17'(gx1[15:0]);
          mpos    <= 19'(gx0[15:0]) + 19'(x1off);
          single  <= (8'(gx1i) <= 8'(gx0i) + 8'd1);
          ccol    <= gx0i;
          xa      <= xb;
          need_xa <= 1'b0;
          if (8'(gx1i) <= 8'(gx0i) + 8'd1) state <= S_C_NUM;
          else state <= S_SQ_HEAD;
        end

        S_SQ_HEAD: begin
          head  <= mul_p[32:0];
          state <= S_SQ_TAIL;
        end

        S_SQ_TAIL: begin
          tail  <= mul_p[32:0];
          state <= S_C_NUM;
        end

        S_C_NUM: begin
          num   <= num_c;
          state <= S_C_MUL;
        end

        S_C_MUL: begin
          prod  <= mul_p[49:0];
          state <= S_C_DIV;
        end

        S_C_DIV: begin
          csign <= prod[49] ^ neg;
          state <= S_C_WAIT;
        end

        S_C_WAIT: begin
          if (div_rsp.done) begin
            if (ccol == (single ? x0i + 7'd1 : x1i)) begin
              state <= S_R_NEXT;
            end else begin
              ccol  <= ccol + 7'd1;
              state <= S_C_NUM;
            end
          end
        end

        S_R_NEXT: begin
          if (yrow + 7'd1 >= ye) begin
            state <= S_IDLE;
          end else begin
            yrow  <= yrow + 7'd1;
            state <= S_R_BEGIN;
          end
        end

        S_F_RD: state <= S_F_ACC;

        S_F_ACC: begin
          acc          <= acc_n;
          valid        <= 1'b1;
          pixel_column <= fcol[5:0];
          pixel_row    <= frow;
          alpha        <= alpha_c;
          last_in_row  <= fill_last;
          if (fill_last) begin
            state <= S_IDLE;
          end else begin
            fcol  <= fcol + 7'd1;
            state <= S_F_RD;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/sacr_checker.sv
// ============================================================================
// sacr_checker: port-level checks for the coverage rasterizer
// Watches the command and result ports for sequencing slips.
// ============================================================================
module sacr_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       valid,
  input logic [5:0] pixel_column,
  input logic [5:0] pixel_row,
  input logic       last_in_row
);

  // Reset starts the clearing sweep, so the block reports busy.
  assert property (@(posedge clk) rst |=> busy)
    else $error("busy not raised after reset");

  // Taking an item never shows a result in the following cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> !valid)
    else $error("result right after an accepted item");

  // A row ends with its last pixel.
  assert property (@(posedge clk) disable iff (rst) (valid && last_in_row) |=> !valid)
    else $error("result after the last pixel of a row");

  // Within a row, valid drops and then the next pixel follows in the next column.
  assert property (@(posedge clk) disable iff (rst)
    (valid && !last_in_row) |=> !valid ##1
      (valid && pixel_row == $past(pixel_row, 2) &&
       pixel_column == $past(pixel_column, 2) + 6'd1))
    else $error("row pixels out of sequence");

  // While a row is still open the block stays busy.
  assert property (@(posedge clk) disable iff (rst) (valid && !last_in_row) |-> busy)
    else $error("idle in the middle of a row");

endmodule

bind signed_area_coverage_rasterizer_top sacr_checker u_sacr_checker (.*);
